// ===== design/tssm_pkg.sv =====
`timescale 1ns / 1ps
package tssm_pkg;

    localparam int CAP_W     = 11;
    localparam int CAP_RESET = 1024;
    localparam int VAL_W     = 32;

    localparam logic [2:0] OP_PUSH_A = 3'd0;
    localparam logic [2:0] OP_PUSH_B = 3'd1;
    localparam logic [2:0] OP_POP_A  = 3'd2;
    localparam logic [2:0] OP_POP_B  = 3'd3;
    localparam logic [2:0] OP_PEEK_A = 3'd4;
    localparam logic [2:0] OP_PEEK_B = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]              opcode;
        logic signed [VAL_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] top_value;
    } t_out_item;

    typedef struct packed {
        logic [1:0] status;
        logic       rd;
        logic       wr;
    } t_q_ctl;

endpackage

// ===== design/tssm_ram.sv =====
`timescale 1ns / 1ps
module tssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tssm_fifo.sv =====
`timescale 1ns / 1ps
module tssm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rptr];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

endmodule

// ===== design/tssm_front.sv =====
`timescale 1ns / 1ps
module tssm_front
    import tssm_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CAP_W-1:0]         i_cfg_data,
    input  logic                     i_push,
    input  t_in_item                 i_item,
    output t_q_ctl                   o_ctl,
    output logic [$clog2(DEPTH)-1:0] o_addr,
    output logic [DATA_WIDTH-1:0]    o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_first, n_first;
    logic [CW-1:0]    r_second, n_second;
    logic [EW-1:0]    w_cap_ext;
    logic [CW-1:0]    w_eff;
    logic [CW:0]      w_sum;
    logic             w_full;

    assign w_cap_ext = EW'(r_cap);
    assign w_eff     = (w_cap_ext > EW'(DEPTH)) ? CW'(DEPTH) : CW'(w_cap_ext);
    assign w_sum     = (CW + 1)'(r_first) + (CW + 1)'(r_second);
    assign w_full    = (w_sum >= (CW + 1)'(w_eff));
    assign o_data    = DATA_WIDTH'($unsigned(i_item.push_value));

    always_comb begin
        n_first      = r_first;
        n_second     = r_second;
        o_ctl.status = ST_OK;
        o_ctl.rd     = 1'b0;
        o_ctl.wr     = 1'b0;
        o_addr       = '0;
        unique case (i_item.opcode)
            OP_PUSH_A: begin
                if (w_full) begin
                    o_ctl.status = ST_OVERFLOW;
                end else begin
                    o_ctl.wr = 1'b1;
                    o_addr   = AW'(r_first);
                    n_first  = r_first + CW'(1);
                end
            end
            OP_PUSH_B: begin
                if (w_full) begin
                    o_ctl.status = ST_OVERFLOW;
                end else begin
                    o_ctl.wr = 1'b1;
                    o_addr   = AW'(w_eff - r_second - CW'(1));
                    n_second = r_second + CW'(1);
                end
            end
            OP_POP_A, OP_PEEK_A: begin
                if (r_first == '0) begin
                    o_ctl.status = ST_UNDERFLOW;
                end else begin
                    o_ctl.rd = 1'b1;
                    o_addr   = AW'(r_first - CW'(1));
                    if (i_item.opcode == OP_POP_A) begin
                        n_first = r_first - CW'(1);
                    end
                end
            end
            OP_POP_B, OP_PEEK_B: begin
                if (r_second == '0 || r_second > w_eff) begin
                    o_ctl.status = ST_UNDERFLOW;
                end else begin
                    o_ctl.rd = 1'b1;
                    o_addr   = AW'(w_eff - r_second);
                    if (i_item.opcode == OP_POP_B) begin
                        n_second = r_second - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_W'(CAP_RESET);
            r_first  <= '0;
            r_second <= '0;
        end else if (i_cfg_we) begin
            r_cap    <= i_cfg_data;
            r_first  <= '0;
            r_second <= '0;
        end else if (i_push) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    a_stacks_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum <= (CW + 1)'(w_eff))
        else $error("stacks overlap");

endmodule

// ===== design/tssm_back.sv =====
`timescale 1ns / 1ps
module tssm_back
    import tssm_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_q_ctl                   i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_WIDTH-1:0]    i_data,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_item
);

    logic                  w_issue;
    logic                  w_p1_move;
    logic                  w_ram_en;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic signed [63:0]    w_ext;
    logic                  r_p1_valid;
    logic [1:0]            r_p1_status;
    logic                  r_p1_rd;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    assign w_p1_move = r_p1_valid && (!r_out_valid || !i_out_stall);
    assign w_issue   = i_q_valid && (!r_p1_valid || w_p1_move);
    assign w_ram_en  = w_issue && (i_ctl.rd || i_ctl.wr);
    assign o_q_pop   = w_issue;

    tssm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (i_ctl.wr),
        .i_addr  (i_addr),
        .i_wdata (i_data),
        .o_rdata (w_rdata)
    );

    // sign extend from the stored width
    assign w_ext = 64'($signed(w_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_p1_valid <= 1'b1;
            end else if (w_p1_move) begin
                r_p1_valid <= 1'b0;
            end
            if (w_p1_move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_p1_status <= i_ctl.status;
            r_p1_rd     <= i_ctl.rd;
        end
        if (w_p1_move) begin
            r_out_item.status    <= r_p1_status;
            r_out_item.top_value <= r_p1_rd ? w_ext[VAL_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status != ST_OK) |-> r_out_item.top_value == '0)
        else $error("failed beat carries a value");

    a_hold_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !w_p1_move) |-> !w_ram_en)
        else $error("memory accessed while read data is held");

endmodule

// ===== design/two_stacks_shared_memory_top.sv =====
`timescale 1ns / 1ps
// channel | valid      | stall       | payload
// in      | i_in_valid | o_in_stall  | i_in_item  (opcode, push_value)
// out     | o_out_valid| i_out_stall | o_out_item (status, top_value)
// cfg     | i_cfg_we   | -           | i_cfg_data (capacity_in_use)
// one beat per cycle unless stalled; result passes queue, RAM, output register
// throughput set by the single memory port, at most one access per beat
// reset clears both stack counts and sets capacity to 1024, memory not cleared
// a two-entry queue and an output register absorb output stalls
module two_stacks_shared_memory_top
    import tssm_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int QW = $bits(t_q_ctl) + AW + DATA_WIDTH;
    localparam int QD = 2;

    logic                  w_push;
    logic                  w_full;
    logic                  w_pop;
    logic                  w_q_valid;
    t_q_ctl                w_f_ctl;
    logic [AW-1:0]         w_f_addr;
    logic [DATA_WIDTH-1:0] w_f_data;
    logic [QW-1:0]         w_q_in;
    logic [QW-1:0]         w_q_out;
    t_q_ctl                w_b_ctl;
    logic [AW-1:0]         w_b_addr;
    logic [DATA_WIDTH-1:0] w_b_data;

    assign w_push     = i_in_valid && !w_full;
    assign o_in_stall = w_full;

    tssm_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (w_push),
        .i_item     (i_in_item),
        .o_ctl      (w_f_ctl),
        .o_addr     (w_f_addr),
        .o_data     (w_f_data)
    );

    assign w_q_in = {w_f_ctl, w_f_addr, w_f_data};

    tssm_fifo #(
        .WIDTH (QW),
        .DEPTH (QD)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign {w_b_ctl, w_b_addr, w_b_data} = w_q_out;

    tssm_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_ctl       (w_b_ctl),
        .i_addr      (w_b_addr),
        .i_data      (w_b_data),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== bench/two_stacks_shared_memory_top_test.sv =====
`timescale 1ns / 1ps
module two_stacks_shared_memory_top_test;
    import tssm_pkg::*;

    localparam int MEM_DEPTH  = 1024;
    localparam int IDLE_LIMIT = 2000;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    class stack_pair_model;
        logic [VAL_W-1:0] shared_mem [MEM_DEPTH];
        int unsigned      lower_count;
        int unsigned      upper_count;
        int unsigned      capacity;
        t_out_item        replies_due [$];
        int               errors;
        int               ops_seen;
        int               overflows;
        int               underflows;
        int               reads_ok;

        function new();
            capacity    = CAP_RESET;
            lower_count = 0;
            upper_count = 0;
            errors      = 0;
            ops_seen    = 0;
            overflows   = 0;
            underflows  = 0;
            reads_ok    = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity    = value;
            lower_count = 0;
            upper_count = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void note_operation(t_in_item op);
            t_out_item   want;
            int unsigned usable;
            usable = (capacity > MEM_DEPTH) ? MEM_DEPTH : capacity;
            want.status    = ST_OK;
            want.top_value = '0;
            ops_seen++;
            case (op.opcode)
                OP_PUSH_A, OP_PUSH_B: begin
                    if (lower_count + upper_count >= usable) begin
                        want.status = ST_OVERFLOW;
                    end else if (op.opcode == OP_PUSH_A) begin
                        shared_mem[lower_count] = op.push_value;
                        lower_count++;
                    end else begin
                        upper_count++;
                        shared_mem[usable - upper_count] = op.push_value;
                    end
                end
                OP_POP_A, OP_PEEK_A: begin
                    if (lower_count == 0) begin
                        want.status = ST_UNDERFLOW;
                    end else begin
                        want.top_value = shared_mem[lower_count - 1];
                        if (op.opcode == OP_POP_A) lower_count--;
                    end
                end
                OP_POP_B, OP_PEEK_B: begin
                    if (upper_count == 0 || upper_count > usable) begin
                        want.status = ST_UNDERFLOW;
                    end else begin
                        want.top_value = shared_mem[usable - upper_count];
                        if (op.opcode == OP_POP_B) upper_count--;
                    end
                end
                default: begin
                end
            endcase
            if (want.status == ST_OVERFLOW) overflows++;
            if (want.status == ST_UNDERFLOW) underflows++;
            if (want.status == ST_OK && op.opcode inside {OP_POP_A, OP_POP_B, OP_PEEK_A, OP_PEEK_B})
                reads_ok++;
            replies_due.push_back(want);
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (replies_due.size() == 0) begin
                $error("reply with nothing pending: status %0d top_value %0d",
                       got.status, got.top_value);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.top_value !== want.top_value) begin
                $error("top_value expected %0d actual %0d", want.top_value, got.top_value);
                errors++;
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    t_in_item         in_item   = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_item;

    stack_pair_model  stacks;
    bit               gaps_on     = 1'b1;
    int               stall_left  = 0;
    int               idle_cycles = 0;
    int               cap_writes  = 0;

    two_stacks_shared_memory_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #6 clk = ~clk;

    // receiver stall bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left != 1);
        end else if (gaps_on && $urandom_range(4) == 0) begin
            stall_left <= $urandom_range(7, 1);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) stacks.check_reply(out_item);
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic issue_op(t_in_item op);
        if (gaps_on && $urandom_range(3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= op;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        stacks.note_operation(op);
    endtask

    task automatic send_op(logic [2:0] opcode, logic [VAL_W-1:0] value);
        t_in_item op;
        op.opcode     = opcode;
        op.push_value = value;
        issue_op(op);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (stacks.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        stacks.set_capacity(value);
        cap_writes++;
    endtask

    function automatic t_in_item rand_op(int push_pct);
        t_in_item op;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            op.opcode = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
        end else if (pick < 3 + push_pct) begin
            op.opcode = $urandom_range(1) ? OP_PUSH_B : OP_PUSH_A;
        end else begin
            case ($urandom_range(3))
                0: op.opcode = OP_POP_A;
                1: op.opcode = OP_POP_B;
                2: op.opcode = OP_PEEK_A;
                default: op.opcode = OP_PEEK_B;
            endcase
        end
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: op.push_value = 32'sh7fff_ffff;
                1: op.push_value = 32'sh8000_0000;
                2: op.push_value = '1;
                default: op.push_value = '0;
            endcase
        end else begin
            op.push_value = $urandom;
        end
        return op;
    endfunction

    task automatic run_mix(int count, int push_pct);
        for (int i = 0; i < count; i++) issue_op(rand_op(push_pct));
    endtask

    initial begin
        stacks = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stacks, value extremes, spare opcodes at reset capacity
        send_op(OP_POP_A, 32'd1);
        send_op(OP_PEEK_A, 32'd2);
        send_op(OP_POP_B, 32'd3);
        send_op(OP_PEEK_B, 32'd4);
        send_op(OP_PUSH_A, 32'h7fff_ffff);
        send_op(OP_PUSH_A, 32'h8000_0000);
        send_op(OP_PUSH_B, 32'hffff_ffff);
        send_op(OP_PUSH_B, 32'h0000_0000);
        send_op(OP_PEEK_A, 32'hffff_ffff);
        send_op(OP_PEEK_B, 32'hffff_ffff);
        send_op(OP_POP_A, 32'd0);
        send_op(OP_POP_A, 32'd0);
        send_op(OP_POP_A, 32'd0);
        send_op(OP_POP_B, 32'd0);
        send_op(OP_POP_B, 32'd0);
        send_op(OP_SPARE_LO, 32'h5a5a_a5a5);
        send_op(OP_SPARE_HI, 32'ha5a5_5a5a);

        // single shared entry
        write_capacity(11'd1);
        send_op(OP_PUSH_B, 32'h0000_1234);
        send_op(OP_PUSH_A, 32'h0000_4321);
        send_op(OP_POP_B, 32'd0);
        send_op(OP_PUSH_A, 32'h0000_5555);
        send_op(OP_POP_B, 32'd0);
        send_op(OP_PEEK_A, 32'd0);

        // no usable entries
        write_capacity(11'd0);
        send_op(OP_PUSH_A, 32'd9);
        send_op(OP_PUSH_B, 32'd9);

        // capacity above memory size, fill to overflow then drain a little
        write_capacity(11'h7ff);
        run_mix(1070, 97);
        run_mix(80, 15);

        write_capacity(11'd1);
        run_mix(60, 45);
        write_capacity(11'd2);
        gaps_on = ($urandom_range(2) != 0);
        run_mix(60, 40);
        write_capacity(11'd3);
        gaps_on = 1'b1;
        run_mix(60, 50);
        write_capacity(11'd0);
        run_mix(20, 50);
        write_capacity(CAP_W'($urandom_range(40, 4)));
        gaps_on = ($urandom_range(2) != 0);
        run_mix(80, 45);
        write_capacity(CAP_W'($urandom_range(2047, 1)));
        gaps_on = 1'b1;
        run_mix(80, 50);
        write_capacity(11'd1024);
        run_mix(60, 30);

        // back to back at full rate
        write_capacity(11'd5);
        gaps_on = 1'b0;
        run_mix(120, 45);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("ran %0d operations across %0d capacity writes", stacks.ops_seen, cap_writes);
        $display("  %0d overflows, %0d underflows, %0d pops or peeks with data",
                 stacks.overflows, stacks.underflows, stacks.reads_ok);
        if (stacks.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tssm_pkg.sv
design/tssm_ram.sv
design/tssm_fifo.sv
design/tssm_front.sv
design/tssm_back.sv
design/two_stacks_shared_memory_top.sv
bench/two_stacks_shared_memory_top_test.sv
